@@ hdl/scfp_pkg.sv @@
// shared types and codes of the sum checked frame parser
package scfp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned PHASE_W  = 4;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [PHASE_W-1:0] PH_HEAD0 = 4'd0;
   localparam logic [PHASE_W-1:0] PH_HEAD1 = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SRC   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_DST   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_CMD   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_LENL  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_LENH  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_PAY   = 4'd7;
   localparam logic [PHASE_W-1:0] PH_CHK   = 4'd8;
   localparam logic [PHASE_W-1:0] PH_DONE  = 4'd9;

   localparam logic [COUNT_W-1:0] MIN_FRAME = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_HEAD  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_SECOND = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              datagram_end;
   } req_data_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [WORD_W-1:0]   payload_index;
      logic [BYTE_W-1:0]   src_addr;
      logic [BYTE_W-1:0]   dst_addr;
      logic [BYTE_W-1:0]   command;
      logic [WORD_W-1:0]   payload_length;
      logic [STATUS_W-1:0] status;
   } rsp_data_type;

endpackage

@@ hdl/scfp_req_if.sv @@
// byte input channel of the frame parser
interface scfp_req_if;
   logic                  valid;
   logic                  ready;
   scfp_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/scfp_rsp_if.sv @@
// result channel of the frame parser
interface scfp_rsp_if;
   logic                  valid;
   logic                  ready;
   scfp_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sum_checked_frame_parser_core.sv @@
// frame parser with header check and additive checksum, top level
// result: registered, valid in the cycle after the beat that causes it is accepted
// throughput: one byte beat per cycle; the only stall is a full result register
// that the sink does not take in the same cycle
// reset: synchronous, clears frame state, header registers and the result valid flag
module sum_checked_frame_parser_core (
   input  logic                                 clock,
   input  logic                                 reset,
   scfp_req_if.sink                             req,
   scfp_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [scfp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]          csr_write_data
);

   logic [scfp_pkg::BYTE_W-1:0]   head_first_ff, head_second_ff;
   logic [scfp_pkg::PHASE_W-1:0]  phase_ff, phase_in, phase_upd;
   logic [scfp_pkg::COUNT_W-1:0]  short_count_ff, short_count_in, short_count_upd;
   logic                          header_bad_ff, header_bad_in, header_bad_upd;
   logic [scfp_pkg::BYTE_W-1:0]   src_ff, src_in, src_upd;
   logic [scfp_pkg::BYTE_W-1:0]   dst_ff, dst_in, dst_upd;
   logic [scfp_pkg::BYTE_W-1:0]   cmd_ff, cmd_in, cmd_upd;
   logic [scfp_pkg::WORD_W-1:0]   length_ff, length_in, length_upd;
   logic [scfp_pkg::WORD_W-1:0]   index_ff, index_in, index_upd;
   logic [scfp_pkg::BYTE_W-1:0]   sum_ff, sum_in, sum_upd;
   logic                          sum_match_ff, sum_match_in, sum_match_upd;
   logic                          rsp_valid_ff, rsp_valid_in;
   scfp_pkg::rsp_data_type        rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          is_payload;
   logic                          emit;
   logic [scfp_pkg::BYTE_W-1:0]   b;
   logic                          last;
   logic [scfp_pkg::STATUS_W-1:0] status;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.data.rx_byte;
   assign last      = req.data.datagram_end;

   // per-byte state update
   always_comb begin
      phase_upd       = phase_ff;
      header_bad_upd  = header_bad_ff;
      src_upd         = src_ff;
      dst_upd         = dst_ff;
      cmd_upd         = cmd_ff;
      length_upd      = length_ff;
      index_upd       = index_ff;
      sum_upd         = sum_ff;
      sum_match_upd   = sum_match_ff;
      is_payload      = 1'b0;
      short_count_upd = (short_count_ff < scfp_pkg::MIN_FRAME) ?
                        4'(short_count_ff + 4'd1) : short_count_ff;
      case (phase_ff)
         scfp_pkg::PH_HEAD0: begin
            if (b != head_first_ff) header_bad_upd = 1'b1;
            phase_upd = scfp_pkg::PH_HEAD1;
         end
         scfp_pkg::PH_HEAD1: begin
            if (b != head_second_ff) header_bad_upd = 1'b1;
            phase_upd = scfp_pkg::PH_SRC;
         end
         scfp_pkg::PH_SRC: begin
            src_upd   = b;
            sum_upd   = 8'(sum_ff + b);
            phase_upd = scfp_pkg::PH_DST;
         end
         scfp_pkg::PH_DST: begin
            dst_upd   = b;
            sum_upd   = 8'(sum_ff + b);
            phase_upd = scfp_pkg::PH_CMD;
         end
         scfp_pkg::PH_CMD: begin
            cmd_upd   = b;
            sum_upd   = 8'(sum_ff + b);
            phase_upd = scfp_pkg::PH_LENL;
         end
         scfp_pkg::PH_LENL: begin
            length_upd = {length_ff[15:8], b};
            sum_upd    = 8'(sum_ff + b);
            phase_upd  = scfp_pkg::PH_LENH;
         end
         scfp_pkg::PH_LENH: begin
            length_upd = {b, length_ff[7:0]};
            sum_upd    = 8'(sum_ff + b);
            index_upd  = '0;
            phase_upd  = ({b, length_ff[7:0]} == 16'd0) ? scfp_pkg::PH_CHK :
                         scfp_pkg::PH_PAY;
         end
         scfp_pkg::PH_PAY: begin
            is_payload = 1'b1;
            sum_upd    = 8'(sum_ff + b);
            if (16'(index_ff + 16'd1) == length_ff) begin
               phase_upd = scfp_pkg::PH_CHK;
            end else begin
               index_upd = 16'(index_ff + 16'd1);
            end
         end
         scfp_pkg::PH_CHK: begin
            sum_match_upd = (sum_ff == b);
            phase_upd     = scfp_pkg::PH_DONE;
         end
         default: begin
         end
      endcase
   end

   // verdict priority
   always_comb begin
      priority if (short_count_upd < scfp_pkg::MIN_FRAME) status = scfp_pkg::ST_SHORT;
      else if (header_bad_upd)                          status = scfp_pkg::ST_BAD_HEAD;
      else if (phase_upd != scfp_pkg::PH_DONE)          status = scfp_pkg::ST_TRUNCATED;
      else if (!sum_match_upd)                          status = scfp_pkg::ST_BAD_SUM;
      else                                              status = scfp_pkg::ST_OK;
   end

   assign emit = last || (is_payload && !header_bad_upd);

   always_comb begin
      rsp_data_in.kind           = last ? scfp_pkg::KIND_VERDICT : scfp_pkg::KIND_PAYLOAD;
      rsp_data_in.payload_byte   = last ? '0 : b;
      rsp_data_in.payload_index  = last ? '0 : index_ff;
      rsp_data_in.src_addr       = src_upd;
      rsp_data_in.dst_addr       = dst_upd;
      rsp_data_in.command        = cmd_upd;
      rsp_data_in.payload_length = length_upd;
      rsp_data_in.status         = last ? status : scfp_pkg::ST_OK;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // frame state: updated per beat, cleared after a verdict
   always_comb begin
      phase_in       = phase_ff;
      short_count_in = short_count_ff;
      header_bad_in  = header_bad_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      cmd_in         = cmd_ff;
      length_in      = length_ff;
      index_in       = index_ff;
      sum_in         = sum_ff;
      sum_match_in   = sum_match_ff;
      if (accept) begin
         if (last) begin
            phase_in       = scfp_pkg::PH_HEAD0;
            short_count_in = '0;
            header_bad_in  = 1'b0;
            src_in         = '0;
            dst_in         = '0;
            cmd_in         = '0;
            length_in      = '0;
            index_in       = '0;
            sum_in         = '0;
            sum_match_in   = 1'b0;
         end else begin
            phase_in       = phase_upd;
            short_count_in = short_count_upd;
            header_bad_in  = header_bad_upd;
            src_in         = src_upd;
            dst_in         = dst_upd;
            cmd_in         = cmd_upd;
            length_in      = length_upd;
            index_in       = index_upd;
            sum_in         = sum_upd;
            sum_match_in   = sum_match_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_first_ff  <= '0;
         head_second_ff <= '0;
         phase_ff       <= scfp_pkg::PH_HEAD0;
         short_count_ff <= '0;
         header_bad_ff  <= 1'b0;
         src_ff         <= '0;
         dst_ff         <= '0;
         cmd_ff         <= '0;
         length_ff      <= '0;
         index_ff       <= '0;
         sum_ff         <= '0;
         sum_match_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               scfp_pkg::CSR_HEAD_FIRST:  head_first_ff  <= csr_write_data;
               scfp_pkg::CSR_HEAD_SECOND: head_second_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         phase_ff       <= phase_in;
         short_count_ff <= short_count_in;
         header_bad_ff  <= header_bad_in;
         src_ff         <= src_in;
         dst_ff         <= dst_in;
         cmd_ff         <= cmd_in;
         length_ff      <= length_in;
         index_ff       <= index_in;
         sum_ff         <= sum_in;
         sum_match_ff   <= sum_match_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   a_end_clears_frame: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> phase_ff == scfp_pkg::PH_HEAD0 && short_count_ff == '0 &&
                         !header_bad_ff && sum_ff == '0)
      else $error("frame state not cleared after end beat");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      short_count_ff <= scfp_pkg::MIN_FRAME)
      else $error("byte count passed its saturation value");

   a_payload_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == scfp_pkg::KIND_PAYLOAD |->
         rsp_data_ff.status == scfp_pkg::ST_OK)
      else $error("payload result carries a status");

   a_good_payload_emits: assert property (@(posedge clock) disable iff (reset)
      accept && !last && phase_ff == scfp_pkg::PH_PAY && !header_bad_ff |=>
         rsp_valid_ff && rsp_data_ff.kind == scfp_pkg::KIND_PAYLOAD)
      else $error("payload beat under good header not forwarded");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= scfp_pkg::PH_DONE)
      else $error("phase out of range");

endmodule
